@@ src/spitq_pkg.sv @@
// ============================================================================
// spitq_pkg
// Shared types, result codes and helpers for the SPI transfer queue sequencer.
// ============================================================================
`default_nettype none

package spitq_pkg;

    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 88;
    localparam int KIND_W     = 3;

    localparam logic OP_ENQUEUE  = 1'b0;
    localparam logic OP_COMPLETE = 1'b1;

    localparam logic [KIND_W-1:0] K_ACCEPTED   = 3'd0;
    localparam logic [KIND_W-1:0] K_REJECTED   = 3'd1;
    localparam logic [KIND_W-1:0] K_START_TX   = 3'd2;
    localparam logic [KIND_W-1:0] K_START_RX   = 3'd3;
    localparam logic [KIND_W-1:0] K_START_TXRX = 3'd4;
    localparam logic [KIND_W-1:0] K_RELEASE    = 3'd5;
    localparam logic [KIND_W-1:0] K_SPURIOUS   = 3'd6;

    typedef struct packed {
        logic [3:0]  cs_index;
        logic        half_duplex;
        logic        has_rx;
        logic        notify;
        logic [31:0] tx_address;
        logic [31:0] rx_address;
        logic [15:0] tx_length;
        logic [15:0] rx_length;
    } desc_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [3:0]        cs_index;
        logic [31:0]       tx_address;
        logic [31:0]       rx_address;
        logic [15:0]       length;
        logic              notify;
        logic              last;
    } res_t;

    typedef struct packed {
        logic capture;
        logic decide;
        logic start_in;
        logic start_mem;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic is_enqueue;
        logic full;
        logic empty;
        logic rx_step;
        logic more;
    } status_t;

    function automatic res_t start_cmd(desc_t d, logic rx_phase);
        res_t r;
        r          = '0;
        r.cs_index = d.cs_index;
        r.last     = 1'b1;
        if (!d.half_duplex)
        begin
            r.kind       = K_START_TXRX;
            r.tx_address = d.tx_address;
            r.rx_address = d.rx_address;
            r.length     = d.tx_length;
        end
        else if (!rx_phase)
        begin
            r.kind       = K_START_TX;
            r.tx_address = d.tx_address;
            r.length     = d.tx_length;
        end
        else
        begin
            r.kind       = K_START_RX;
            r.rx_address = d.rx_address;
            r.length     = d.rx_length;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ src/spi_transaction_queue_sequencer.sv @@
// ============================================================================
// spi_transaction_queue_sequencer
// Ring of SPI transfer descriptors that issues start/release commands and status results.
// ============================================================================
// An item is captured in S_IDLE; its first result is registered in S_DECIDE
//   once the output register is free. An enqueue that starts the new entry
//   adds S_START; a release followed by the next start adds S_READ, a store
//   reread for the registered head read, and S_START. s_tready is high only in S_IDLE.
// Reset: asynchronous, clears indices, count, phase and valid; store untouched.
`default_nettype none

module spi_transaction_queue_sequencer #(
    parameter int QUEUE_DEPTH = 8
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // cs_index, half_duplex, has_rx, notify, tx_address, rx_address,
    // tx_length, rx_length, zero pad
    input  wire logic [spitq_pkg::IN_DATA_W-1:0]  s_tdata,
    // operation
    input  wire logic                             s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // out_cs_index, out_tx_address, out_rx_address, out_length, out_notify,
    // zero pad
    output logic [spitq_pkg::OUT_DATA_W-1:0]      m_tdata,
    // result_kind
    output logic [spitq_pkg::KIND_W-1:0]          m_tuser,
    output logic                                  m_tlast
);
    import spitq_pkg::*;

    cmd_t    cmd;
    status_t st;
    desc_t   in_desc;
    res_t    out_res;

    assign in_desc.cs_index    = s_tdata[3:0];
    assign in_desc.half_duplex = s_tdata[4];
    assign in_desc.has_rx      = s_tdata[5];
    assign in_desc.notify      = s_tdata[6];
    assign in_desc.tx_address  = s_tdata[38:7];
    assign in_desc.rx_address  = s_tdata[70:39];
    assign in_desc.tx_length   = s_tdata[86:71];
    assign in_desc.rx_length   = s_tdata[102:87];

    spitq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    spitq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .in_op     (s_tuser),
        .in_desc   (in_desc),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {3'b000, out_res.notify, out_res.length, out_res.rx_address,
                      out_res.tx_address, out_res.cs_index};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

endmodule

`default_nettype wire

@@ src/spitq_ctrl.sv @@
// ============================================================================
// spitq_ctrl
// Sequencing state machine: accept, decide, optional reread, optional second result.
// ============================================================================
`default_nettype none

module spitq_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire spitq_pkg::status_t st,
    output spitq_pkg::cmd_t        cmd
);
    import spitq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_READ,
        S_START
    } state_t;

    state_t state_reg, state_next;
    logic   src_mem_reg, src_mem_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        src_mem_next = src_mem_reg;
        cmd          = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (st.out_free)
                begin
                    cmd.decide = 1'b1;
                    state_next = S_IDLE;
                    if (st.is_enqueue)
                    begin
                        if (!st.full && st.empty)
                        begin
                            state_next   = S_START;
                            src_mem_next = 1'b0;
                        end
                    end
                    else if (!st.empty && !st.rx_step && st.more)
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next   = S_START;
                src_mem_next = 1'b1;
            end
            S_START:
            begin
                if (st.out_free)
                begin
                    cmd.start_in  = !src_mem_reg;
                    cmd.start_mem = src_mem_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            src_mem_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            src_mem_reg <= src_mem_next;
        end
    end

endmodule

`default_nettype wire

@@ src/spitq_dp.sv @@
// ============================================================================
// spitq_dp
// Descriptor ring, head/tail/count, phase flag and output register.
// ============================================================================
`default_nettype none

module spitq_dp #(
    parameter int QUEUE_DEPTH = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire spitq_pkg::cmd_t   cmd,
    output spitq_pkg::status_t     st,
    input  wire logic              in_op,
    input  wire spitq_pkg::desc_t  in_desc,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output spitq_pkg::res_t        out_res
);
    import spitq_pkg::*;

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    desc_t            desc_mem [QUEUE_DEPTH];
    desc_t            rdata_reg;
    desc_t            in_desc_reg, in_desc_next;
    logic             in_op_reg, in_op_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             rx_phase_reg, rx_phase_next;
    logic             out_valid_reg, out_valid_next;
    res_t             out_res_reg, out_res_next;
    logic             wr_en;

    function automatic logic [IDX_W-1:0] next_slot(logic [IDX_W-1:0] i);
        return (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    assign st.out_free   = !out_valid_reg || out_ready;
    assign st.is_enqueue = (in_op_reg == OP_ENQUEUE);
    assign st.full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign st.empty      = (count_reg == '0);
    assign st.rx_step    = rdata_reg.half_duplex && rdata_reg.has_rx && !rx_phase_reg;
    assign st.more       = (count_reg > CNT_W'(1));

    always_comb
    begin
        in_op_next     = in_op_reg;
        in_desc_next   = in_desc_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        rx_phase_next  = rx_phase_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_res_next   = out_res_reg;
        wr_en          = 1'b0;

        if (cmd.capture)
        begin
            in_op_next   = in_op;
            in_desc_next = in_desc;
        end

        if (cmd.decide)
        begin
            out_valid_next = 1'b1;
            out_res_next   = '0;
            out_res_next.last = 1'b1;
            if (in_op_reg == OP_ENQUEUE)
            begin
                if (st.full)
                begin
                    out_res_next.kind = K_REJECTED;
                end
                else
                begin
                    wr_en             = 1'b1;
                    tail_next         = next_slot(tail_reg);
                    count_next        = count_reg + 1'b1;
                    out_res_next.kind = K_ACCEPTED;
                    out_res_next.last = !st.empty;
                end
            end
            else if (st.empty)
            begin
                out_res_next.kind = K_SPURIOUS;
            end
            else if (st.rx_step)
            begin
                rx_phase_next = 1'b1;
                out_res_next  = start_cmd(rdata_reg, 1'b1);
            end
            else
            begin
                out_res_next.kind     = K_RELEASE;
                out_res_next.cs_index = rdata_reg.cs_index;
                out_res_next.notify   = rdata_reg.notify;
                out_res_next.last     = !st.more;
                head_next             = next_slot(head_reg);
                count_next            = count_reg - 1'b1;
                rx_phase_next         = 1'b0;
            end
        end

        if (cmd.start_in)
        begin
            out_valid_next = 1'b1;
            out_res_next   = start_cmd(in_desc_reg, 1'b0);
        end

        if (cmd.start_mem)
        begin
            out_valid_next = 1'b1;
            out_res_next   = start_cmd(rdata_reg, rx_phase_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            desc_mem[tail_reg] <= in_desc_reg;
        end
        rdata_reg <= desc_mem[head_reg];
    end

    always_ff @(posedge clk)
    begin
        in_op_reg   <= in_op_next;
        in_desc_reg <= in_desc_next;
        out_res_reg <= out_res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            rx_phase_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            rx_phase_reg  <= rx_phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ src/spitq_checker.sv @@
// ============================================================================
// spitq_checker
// Port-level checks for the SPI transfer queue sequencer.
// ============================================================================
`default_nettype none

module spitq_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    input  wire logic                             s_tready,
    input  wire logic                             m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic [spitq_pkg::OUT_DATA_W-1:0] m_tdata,
    input  wire logic [spitq_pkg::KIND_W-1:0]     m_tuser,
    input  wire logic                             m_tlast
);
    import spitq_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item taken while previous one in work");

    a_status_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == K_ACCEPTED || m_tuser == K_REJECTED
            || m_tuser == K_SPURIOUS) |-> (m_tdata == '0))
        else $error("status result carries data");

    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == K_REJECTED || m_tuser == K_SPURIOUS
            || m_tuser == K_START_RX) |-> m_tlast)
        else $error("single result not marked last");

endmodule

bind spi_transaction_queue_sequencer spitq_checker u_spitq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

@@ tb/tb_spi_transaction_queue_sequencer.sv @@
// ----------------------------------------------------------------------------
// tb_spi_transaction_queue_sequencer
// Drives enqueues and completion events into the SPI descriptor ring, with
// random idle gaps and output stalls. A behavioral copy of the ring predicts
// the results, but for directed rows that give their expected kind, and each result is
// checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_spi_transaction_queue_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    import spitq_pkg::*;

    localparam int RING_SLOTS   = 8;
    localparam int RANDOM_ITEMS = 1625;
    localparam int MAX_REPORTS  = 10;
    localparam desc_t NO_DESC   = '0;

    typedef struct packed {
        logic              op;
        desc_t             desc;
        logic              typed;
        logic [KIND_W-1:0] typed_kind;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]     m_tuser;
    logic                  m_tlast;

    // predicted ring state
    desc_t      ring [RING_SLOTS];
    logic [2:0] ring_head;
    logic [2:0] ring_tail;
    logic [3:0] ring_count;
    logic       busy;
    logic       in_rx_phase;

    res_t pending_cmds [$];
    int   err_count;
    logic quiet;

    stim_row_t directed_rows [25] = '{
        '{OP_COMPLETE, NO_DESC, 1'b1, K_SPURIOUS},
        '{OP_ENQUEUE, '{4'hF, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            16'hFFFF, 16'hFFFF}, 1'b0, K_ACCEPTED},
        '{OP_COMPLETE, NO_DESC, 1'b0, K_ACCEPTED},
        '{OP_ENQUEUE, '{4'h0, 1'b1, 1'b1, 1'b0, 32'h0, 32'h0, 16'h0, 16'h0},
            1'b0, K_ACCEPTED},
        '{OP_COMPLETE, NO_DESC, 1'b0, K_ACCEPTED},
        '{OP_COMPLETE, NO_DESC, 1'b0, K_ACCEPTED},
        '{OP_ENQUEUE, '{4'h5, 1'b1, 1'b0, 1'b1, 32'hA5A5_0001, 32'h5A5A_0002,
            16'h1234, 16'h4321}, 1'b0, K_ACCEPTED},
        '{OP_ENQUEUE, '{4'h1, 1'b0, 1'b0, 1'b0, 32'h1111_0000, 32'h0000_1111,
            16'h0001, 16'h0000}, 1'b0, K_ACCEPTED},
        '{OP_ENQUEUE, '{4'h2, 1'b0, 1'b1, 1'b1, 32'h2222_0000, 32'h0000_2222,
            16'h0002, 16'hFFFF}, 1'b0, K_ACCEPTED},
        '{OP_ENQUEUE, '{4'h3, 1'b0, 1'b0, 1'b0, 32'h3333_0000, 32'h0000_3333,
            16'h8000, 16'h0000}, 1'b0, K_ACCEPTED},
        '{OP_ENQUEUE, '{4'h4, 1'b0, 1'b1, 1'b1, 32'h4444_0000, 32'h0000_4444,
            16'h7FFF, 16'h0001}, 1'b0, K_ACCEPTED},
        '{OP_ENQUEUE, '{4'h8, 1'b0, 1'b0, 1'b0, 32'h8888_0000, 32'h0000_8888,
            16'hFFFF, 16'h0000}, 1'b0, K_ACCEPTED},
        '{OP_ENQUEUE, '{4'hA, 1'b0, 1'b1, 1'b1, 32'hAAAA_0000, 32'h0000_AAAA,
            16'h00FF, 16'hFF00}, 1'b0, K_ACCEPTED},
        '{OP_ENQUEUE, '{4'hE, 1'b0, 1'b0, 1'b1, 32'hEEEE_0000, 32'h0000_EEEE,
            16'hFF00, 16'h00FF}, 1'b0, K_ACCEPTED},
        '{OP_ENQUEUE, '{4'h7, 1'b1, 1'b1, 1'b1, 32'h7777_7777, 32'h7777_7777,
            16'h7777, 16'h7777}, 1'b1, K_REJECTED},
        '{OP_ENQUEUE, '{4'hF, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF, 32'h0,
            16'hFFFF, 16'h0}, 1'b1, K_REJECTED},
        '{OP_COMPLETE, NO_DESC, 1'b0, K_ACCEPTED},
        '{OP_COMPLETE, NO_DESC, 1'b0, K_ACCEPTED},
        '{OP_COMPLETE, NO_DESC, 1'b0, K_ACCEPTED},
        '{OP_COMPLETE, NO_DESC, 1'b0, K_ACCEPTED},
        '{OP_COMPLETE, NO_DESC, 1'b0, K_ACCEPTED},
        '{OP_COMPLETE, NO_DESC, 1'b0, K_ACCEPTED},
        '{OP_COMPLETE, NO_DESC, 1'b0, K_ACCEPTED},
        '{OP_COMPLETE, NO_DESC, 1'b0, K_ACCEPTED},
        '{OP_COMPLETE, NO_DESC, 1'b1, K_SPURIOUS}
    };

    spi_transaction_queue_sequencer u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // start command for the head entry in its current phase
    function automatic void push_head_start(logic is_last);
        desc_t h;
        res_t  r;
        h          = ring[ring_head];
        r          = '0;
        r.cs_index = h.cs_index;
        r.last     = is_last;
        if (!h.half_duplex)
        begin
            r.kind       = K_START_TXRX;
            r.tx_address = h.tx_address;
            r.rx_address = h.rx_address;
            r.length     = h.tx_length;
        end
        else if (!in_rx_phase)
        begin
            r.kind       = K_START_TX;
            r.tx_address = h.tx_address;
            r.length     = h.tx_length;
        end
        else
        begin
            r.kind       = K_START_RX;
            r.rx_address = h.rx_address;
            r.length     = h.rx_length;
        end
        pending_cmds.push_back(r);
    endfunction

    function automatic void sequence_item(logic op, desc_t d);
        res_t r;
        r = '0;
        if (op == OP_ENQUEUE)
        begin
            if (ring_count == 4'(RING_SLOTS))
            begin
                r.kind = K_REJECTED;
                r.last = 1'b1;
                pending_cmds.push_back(r);
            end
            else
            begin
                ring[ring_tail] = d;
                ring_tail       = ring_tail + 3'd1;
                ring_count      = ring_count + 4'd1;
                r.kind          = K_ACCEPTED;
                r.last          = busy;
                pending_cmds.push_back(r);
                if (!busy)
                begin
                    busy        = 1'b1;
                    in_rx_phase = 1'b0;
                    push_head_start(1'b1);
                end
            end
        end
        else if (!busy || ring_count == 4'd0)
        begin
            r.kind = K_SPURIOUS;
            r.last = 1'b1;
            pending_cmds.push_back(r);
        end
        else if (ring[ring_head].half_duplex && ring[ring_head].has_rx && !in_rx_phase)
        begin
            in_rx_phase = 1'b1;
            push_head_start(1'b1);
        end
        else
        begin
            r.kind      = K_RELEASE;
            r.cs_index  = ring[ring_head].cs_index;
            r.notify    = ring[ring_head].notify;
            ring_head   = ring_head + 3'd1;
            ring_count  = ring_count - 4'd1;
            in_rx_phase = 1'b0;
            r.last      = (ring_count == 4'd0);
            pending_cmds.push_back(r);
            if (ring_count != 4'd0)
                push_head_start(1'b1);
            else
                busy = 1'b0;
        end
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic drive_item(logic op, desc_t d, logic typed, logic [KIND_W-1:0] tk);
        int   gap;
        res_t r;
        gap = quiet ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, d.rx_length, d.tx_length, d.rx_address, d.tx_address,
                     d.notify, d.has_rx, d.half_duplex, d.cs_index};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (typed)
        begin
            r      = '0;
            r.kind = tk;
            r.last = 1'b1;
            pending_cmds.push_back(r);
        end
        else
            sequence_item(op, d);
        @(negedge clk);
    endtask

    initial
    begin
        int          enq_pct;
        logic        op;
        desc_t       d;
        stim_row_t   row;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        rst_n       = 1'b0;
        quiet       = 1'b0;
        err_count   = 0;
        ring_head   = '0;
        ring_tail   = '0;
        ring_count  = '0;
        busy        = 1'b0;
        in_rx_phase = 1'b0;
        enq_pct     = 50;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            drive_item(row.op, row.desc, row.typed, row.typed_kind);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 64 == 0)
            begin
                case ($urandom_range(0, 3))
                    0: enq_pct = 25;
                    1: enq_pct = 50;
                    2: enq_pct = 75;
                    default: enq_pct = 90;
                endcase
                quiet = ($urandom_range(0, 3) == 0);
            end
            op            = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_COMPLETE;
            d.cs_index    = 4'($urandom);
            d.half_duplex = 1'($urandom);
            d.has_rx      = 1'($urandom);
            d.notify      = 1'($urandom);
            d.tx_address  = $urandom;
            d.rx_address  = $urandom;
            d.tx_length   = 16'($urandom_range(0, 65535));
            d.rx_length   = 16'($urandom_range(0, 65535));
            drive_item(op, d, 1'b0, K_ACCEPTED);
        end
        s_tvalid <= 1'b0;

        while (pending_cmds.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (err_count == 0 && pending_cmds.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got            = '0;
            got.kind       = m_tuser;
            got.cs_index   = m_tdata[3:0];
            got.tx_address = m_tdata[35:4];
            got.rx_address = m_tdata[67:36];
            got.length     = m_tdata[83:68];
            got.notify     = m_tdata[84];
            got.last       = m_tlast;
            if (pending_cmds.size() == 0)
            begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("unexpected item: kind %0d cs %h tx %h rx %h len %h ntf %b last %b",
                             got.kind, got.cs_index, got.tx_address, got.rx_address,
                             got.length, got.notify, got.last);
            end
            else
            begin
                want = pending_cmds.pop_front();
                if (got.kind !== want.kind || got.cs_index !== want.cs_index ||
                    got.tx_address !== want.tx_address ||
                    got.rx_address !== want.rx_address ||
                    got.length !== want.length || got.notify !== want.notify ||
                    got.last !== want.last)
                begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                    begin
                        $display("mismatch exp: kind %0d cs %h tx %h rx %h len %h ntf %b last %b",
                                 want.kind, want.cs_index, want.tx_address,
                                 want.rx_address, want.length, want.notify, want.last);
                        $display("         got: kind %0d cs %h tx %h rx %h len %h ntf %b last %b",
                                 got.kind, got.cs_index, got.tx_address,
                                 got.rx_address, got.length, got.notify, got.last);
                    end
                end
            end
        end
    end

endmodule

@@ filelist.f @@
src/spitq_pkg.sv
src/spitq_ctrl.sv
src/spitq_dp.sv
src/spi_transaction_queue_sequencer.sv
src/spitq_checker.sv
tb/tb_spi_transaction_queue_sequencer.sv
